// ===== rtl/abt_pkg.sv =====
// Shared types, constants and command codes of the access bitmap tracker.
package abt_pkg;

  localparam int ADDR_BITS        = 48;
  localparam int SIZE_W           = 8;
  localparam int FOUND_W          = 10;
  localparam int PAGE_SHIFT_MIN   = 8;
  localparam int PG_MAX_W         = ADDR_BITS - PAGE_SHIFT_MIN;
  localparam int BK_MAX_W         = 16;
  localparam int QUEUE_DEPTH      = 2;

  localparam int DEF_PAGE_SHIFT   = 12;
  localparam int DEF_BUCKET_SHIFT = 2;
  localparam int DEF_PAGE_SLOTS   = 16;

  localparam logic [1:0] CMD_MARK = 2'd0;
  localparam logic [1:0] CMD_TEST = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;
  localparam logic [1:0] CMD_PREV = 2'd3;

  typedef struct packed {
    logic [1:0]           cmd;
    logic                 access_kind;
    logic [ADDR_BITS-1:0] address;
    logic [SIZE_W-1:0]    access_size;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [FOUND_W-1:0] found_bucket;
    logic               page_present;
    logic               overflow;
  } out_t;

  // Classified item: page, span limits in buckets, and which spans to mark.
  typedef struct packed {
    logic [1:0]          cmd;
    logic                kind;
    logic [PG_MAX_W-1:0] page;
    logic                do1;
    logic                do2;
    logic [BK_MAX_W-1:0] b_first;
    logic [BK_MAX_W-1:0] b_last;
    logic [BK_MAX_W-1:0] b2_last;
  } job_t;

endpackage

// ===== rtl/abt_front.sv =====
// Front end: configuration register and classification of an item into a job.
module abt_front #(
  parameter int PAGE_SHIFT   = abt_pkg::DEF_PAGE_SHIFT,
  parameter int BUCKET_SHIFT = abt_pkg::DEF_BUCKET_SHIFT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  abt_pkg::in_t  in_item,
  output abt_pkg::job_t job
);

  localparam int PG_W       = abt_pkg::ADDR_BITS - PAGE_SHIFT;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;

  logic                  coalescing_r;
  logic [PG_W-1:0]       page;
  logic [16:0]           off17;
  logic [16:0]           size17;
  logic [16:0]           avail;
  logic [16:0]           n1;
  logic [16:0]           end1;
  logic [16:0]           rem;
  logic [15:0]           bucket;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coalescing_r <= 1'b1;
    end else if (cfg_wr_en) begin
      coalescing_r <= cfg_wr_data;
    end
  end

  always_comb begin
    page   = in_item.address[abt_pkg::ADDR_BITS-1:PAGE_SHIFT];
    off17  = 17'(in_item.address[PAGE_SHIFT-1:0]);
    size17 = 17'(in_item.access_size);
    avail  = 17'(PAGE_BYTES) - off17;
    n1     = (size17 < avail) ? size17 : avail;
    end1   = off17 + n1 - 17'd1;
    rem    = size17 - n1;
    bucket = 16'(off17 >> BUCKET_SHIFT);

    job.cmd     = in_item.cmd;
    job.kind    = in_item.access_kind;
    job.page    = abt_pkg::PG_MAX_W'(page);
    job.b_first = bucket;
    job.b_last  = bucket;
    job.b2_last = 16'((rem - 17'd1) >> BUCKET_SHIFT);
    job.do1     = 1'b0;
    job.do2     = 1'b0;
    if (in_item.cmd == abt_pkg::CMD_MARK) begin
      if (!coalescing_r) begin
        job.do1 = 1'b1;
      end else if (in_item.access_size != '0) begin
        job.do1    = 1'b1;
        job.b_last = 16'(end1 >> BUCKET_SHIFT);
        // tail goes to the next page unless this is the top page
        job.do2    = (rem != '0) && !(&page);
      end
    end
  end

endmodule

// ===== rtl/abt_queue.sv =====
// Small job queue between the front end and the back end.
module abt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  abt_pkg::job_t push_job,
  input  logic          pop,
  output abt_pkg::job_t head_job,
  output logic          full,
  output logic          not_empty
);

  localparam int PTR_W = $clog2(abt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(abt_pkg::QUEUE_DEPTH + 1);

  abt_pkg::job_t     q_mem_r [abt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full      = (cnt_r == CNT_W'(abt_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/abt_back.sv =====
// Back end: slot table, bitmap memories and the mark / test / find sequencer.
module abt_back #(
  parameter int PAGE_SHIFT   = abt_pkg::DEF_PAGE_SHIFT,
  parameter int BUCKET_SHIFT = abt_pkg::DEF_BUCKET_SHIFT,
  parameter int PAGE_SLOTS   = abt_pkg::DEF_PAGE_SLOTS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_avail,
  input  abt_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  output abt_pkg::out_t out_item
);

  localparam int PG_W      = abt_pkg::ADDR_BITS - PAGE_SHIFT;
  localparam int BK_W      = PAGE_SHIFT - BUCKET_SHIFT;
  localparam int WPP       = (BK_W > 6) ? (1 << (BK_W - 6)) : 1;
  localparam int WD_W      = (BK_W > 6) ? (BK_W - 6) : 1;
  localparam int SLOT_W    = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
  localparam int MEM_DEPTH = PAGE_SLOTS * WPP;
  localparam int MA_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_RES  = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_MRD  = 3'd4;
  localparam logic [2:0] ST_MWR  = 3'd5;
  localparam logic [2:0] ST_FRD  = 3'd6;
  localparam logic [2:0] ST_FND  = 3'd7;

  localparam logic [1:0] PH_SPAN1 = 2'd0;
  localparam logic [1:0] PH_SPAN2 = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  logic [2:0]            st_r;
  logic [1:0]            phase_r;
  abt_pkg::job_t         job_r;
  logic                  ovf_r;
  logic                  first_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [WD_W-1:0]       word_r;
  logic [PAGE_SLOTS-1:0] match_r;
  logic                  slot_valid_r [PAGE_SLOTS];
  logic [PG_W-1:0]       slot_page_r  [PAGE_SLOTS];
  logic                  out_valid_r;
  abt_pkg::out_t         out_r;
  logic [63:0]           rq_r;
  logic [63:0]           wq_r;

  logic [63:0]           rbm_mem [MEM_DEPTH];
  logic [63:0]           wbm_mem [MEM_DEPTH];

  logic [PG_W-1:0]       cur_page;
  logic [15:0]           span_first;
  logic [15:0]           span_last;
  logic [WD_W-1:0]       fw;
  logic [WD_W-1:0]       lw;
  logic [WD_W-1:0]       scan_word0;
  logic [5:0]            start_bit;
  logic [5:0]            lo_bit;
  logic [5:0]            hi_bit;
  logic [PAGE_SLOTS-1:0] free_vec;
  logic [MA_W-1:0]       mem_addr;
  logic [63:0]           q_sel;
  logic [63:0]           mark_mask;
  logic [63:0]           find_mask;
  logic [63:0]           masked;
  logic [15:0]           found_lo;
  logic [15:0]           found_hi;
  logic [1:0]            next_phase;
  logic                  rbm_we;
  logic                  wbm_we;
  logic                  mem_re;
  logic [63:0]           mem_wdata;

  function automatic logic [SLOT_W-1:0] first_slot(input logic [PAGE_SLOTS-1:0] v);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = SLOT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [5:0] low_one(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [5:0] high_one(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  always_comb begin
    cur_page   = (phase_r == PH_SPAN2) ? job_r.page[PG_W-1:0] + PG_W'(1)
                                       : job_r.page[PG_W-1:0];
    span_first = (phase_r == PH_SPAN2) ? 16'd0 : job_r.b_first;
    span_last  = (phase_r == PH_SPAN2) ? job_r.b2_last : job_r.b_last;
    fw         = WD_W'(span_first >> 6);
    lw         = WD_W'(span_last >> 6);
    scan_word0 = WD_W'(job_r.b_first >> 6);
    start_bit  = job_r.b_first[5:0];
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      free_vec[i] = !slot_valid_r[i];
    end
    mem_addr   = MA_W'(slot_r) * MA_W'(WPP) + MA_W'(word_r);
    q_sel      = job_r.kind ? wq_r : rq_r;
    lo_bit     = (word_r == fw) ? span_first[5:0] : 6'd0;
    hi_bit     = (word_r == lw) ? span_last[5:0] : 6'd63;
    mark_mask  = ({64{1'b1}} << lo_bit) & ({64{1'b1}} >> (6'd63 - hi_bit));
    if (job_r.cmd == abt_pkg::CMD_NEXT) begin
      find_mask = {64{1'b1}} << (first_r ? start_bit : 6'd0);
    end else begin
      find_mask = {64{1'b1}} >> (first_r ? (6'd63 - start_bit) : 6'd0);
    end
    masked     = q_sel & find_mask;
    found_lo   = (16'(word_r) << 6) | 16'(low_one(masked));
    found_hi   = (16'(word_r) << 6) | 16'(high_one(masked));
    next_phase = (phase_r == PH_SPAN1 && job_r.do2) ? PH_SPAN2 : PH_FINAL;
    rbm_we     = (st_r == ST_CLR) || (st_r == ST_MWR && !job_r.kind);
    wbm_we     = (st_r == ST_CLR) || (st_r == ST_MWR && job_r.kind);
    mem_re     = (st_r == ST_MRD) || (st_r == ST_FRD);
    mem_wdata  = (st_r == ST_CLR) ? 64'd0 : (q_sel | mark_mask);
  end

  assign pop       = (st_r == ST_IDLE) && job_avail;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (rbm_we) begin
      rbm_mem[mem_addr] <= mem_wdata;
    end
    if (wbm_we) begin
      wbm_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rq_r <= rbm_mem[mem_addr];
      wq_r <= wbm_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= PH_FINAL;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        slot_valid_r[i] <= 1'b0;
      end
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (job_avail) begin
            job_r   <= head_job;
            ovf_r   <= 1'b0;
            phase_r <= (head_job.cmd == abt_pkg::CMD_MARK && head_job.do1) ? PH_SPAN1
                                                                           : PH_FINAL;
            st_r    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          for (int i = 0; i < PAGE_SLOTS; i++) begin
            match_r[i] <= slot_valid_r[i] && (slot_page_r[i] == cur_page);
          end
          st_r <= ST_RES;
        end
        ST_RES: begin
          if (phase_r == PH_FINAL) begin
            slot_r <= first_slot(match_r);
            if (job_r.cmd == abt_pkg::CMD_MARK || !(|match_r)) begin
              out_valid_r        <= 1'b1;
              out_r.hit          <= 1'b0;
              out_r.found_bucket <= '0;
              out_r.page_present <= |match_r;
              out_r.overflow     <= ovf_r;
              st_r               <= ST_IDLE;
            end else begin
              word_r  <= scan_word0;
              first_r <= 1'b1;
              st_r    <= ST_FRD;
            end
          end else if (|match_r) begin
            slot_r <= first_slot(match_r);
            word_r <= fw;
            st_r   <= ST_MRD;
          end else if (|free_vec) begin
            // new page: take lowest free slot and wipe both bitmaps
            slot_valid_r[first_slot(free_vec)] <= 1'b1;
            slot_page_r[first_slot(free_vec)]  <= cur_page;
            slot_r <= first_slot(free_vec);
            word_r <= '0;
            st_r   <= ST_CLR;
          end else begin
            ovf_r   <= 1'b1;
            phase_r <= next_phase;
            st_r    <= ST_LOOK;
          end
        end
        ST_CLR: begin
          if (word_r == WD_W'(WPP - 1)) begin
            word_r <= fw;
            st_r   <= ST_MRD;
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        ST_MRD: begin
          st_r <= ST_MWR;
        end
        ST_MWR: begin
          if (word_r == lw) begin
            phase_r <= next_phase;
            st_r    <= ST_LOOK;
          end else begin
            word_r <= word_r + 1'b1;
            st_r   <= ST_MRD;
          end
        end
        ST_FRD: begin
          st_r <= ST_FND;
        end
        ST_FND: begin
          first_r <= 1'b0;
          if (job_r.cmd == abt_pkg::CMD_TEST) begin
            out_valid_r        <= 1'b1;
            out_r.hit          <= q_sel[start_bit];
            out_r.found_bucket <= '0;
            out_r.page_present <= 1'b1;
            out_r.overflow     <= 1'b0;
            st_r               <= ST_IDLE;
          end else if (masked != '0) begin
            out_valid_r        <= 1'b1;
            out_r.hit          <= 1'b1;
            out_r.found_bucket <= (job_r.cmd == abt_pkg::CMD_NEXT)
                                  ? found_lo[abt_pkg::FOUND_W-1:0]
                                  : found_hi[abt_pkg::FOUND_W-1:0];
            out_r.page_present <= 1'b1;
            out_r.overflow     <= 1'b0;
            st_r               <= ST_IDLE;
          end else if ((job_r.cmd == abt_pkg::CMD_NEXT && word_r == WD_W'(WPP - 1)) ||
                       (job_r.cmd == abt_pkg::CMD_PREV && word_r == '0)) begin
            out_valid_r        <= 1'b1;
            out_r.hit          <= 1'b0;
            out_r.found_bucket <= '0;
            out_r.page_present <= 1'b1;
            out_r.overflow     <= 1'b0;
            st_r               <= ST_IDLE;
          end else begin
            word_r <= (job_r.cmd == abt_pkg::CMD_NEXT) ? word_r + 1'b1 : word_r - 1'b1;
            st_r   <= ST_FRD;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_ovf_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.overflow) |-> !out_r.hit)
    else $error("overflow reported together with a hit");

  a_hit_needs_page: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.hit) |-> out_r.page_present)
    else $error("hit reported on an absent page");

  a_clear_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLR) |-> slot_valid_r[slot_r])
    else $error("clearing bitmaps of an unallocated slot");

endmodule

// ===== rtl/access_bitmap_tracker_core.sv =====
// Top level of the access bitmap tracker: front end, job queue and back end.
//
// Items are taken with start while busy is low; each item gives exactly one
// result, shown for a single cycle with out_valid. The receiver cannot stall,
// so results must be captured on the cycle they appear. A two-entry job queue
// sits between the classifier and the sequencer, so up to two items can be
// taken while one is in flight. All work runs through one sequencer sharing
// one port on each bitmap memory. Per item from the queue head, a test reads
// one bitmap word; a find reads bitmap words one at a time until a hit or the
// page edge; a test or find of an absent page reads none; a mark reads and
// writes each word of each touched span, and first clears all words_per_page
// words (16 at defaults) of a page that takes a new slot.
module access_bitmap_tracker_core #(
  parameter int PAGE_SHIFT   = abt_pkg::DEF_PAGE_SHIFT,
  parameter int BUCKET_SHIFT = abt_pkg::DEF_BUCKET_SHIFT,
  parameter int PAGE_SLOTS   = abt_pkg::DEF_PAGE_SLOTS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  abt_pkg::in_t  in_item,
  output logic          out_valid,
  output abt_pkg::out_t out_item,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);

  abt_pkg::job_t new_job;
  abt_pkg::job_t head_job;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic          in_xfer;

  // a transfer happens when start is high and the queue has room
  assign busy    = q_full;
  assign in_xfer = start && !q_full;

  abt_front #(
    .PAGE_SHIFT   (PAGE_SHIFT),
    .BUCKET_SHIFT (BUCKET_SHIFT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .job         (new_job)
  );

  abt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_job  (new_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  abt_back #(
    .PAGE_SHIFT   (PAGE_SHIFT),
    .BUCKET_SHIFT (BUCKET_SHIFT),
    .PAGE_SLOTS   (PAGE_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (q_not_empty),
    .head_job  (head_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
